[rtl/core/assert_macros.svh]
// Assertion macros for the RTL of the frame decoder, included by its top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// cond must never hold while out of reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed: forbidden condition seen");
// ante implies cons in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication violated");
`else
`define ASSERT_NEVER(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/htfd_pkg.sv]
// Types, constants and helper functions of the humidity/temperature frame decoder.
package htfd_pkg;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   localparam int TPROD_W = 31;   // 17500 * 65535 < 2**31
   localparam int HPROD_W = 30;   // 10000 * 65535 < 2**30
   localparam logic [14:0] TEMP_SPAN = 15'd17500;
   localparam logic [13:0] HUM_SPAN  = 14'd10000;
   localparam logic [14:0] TEMP_OFFSET = 15'd4500;
   localparam logic [16:0] WORD_FULL = 17'd65535;

   localparam logic signed [14:0] TEMP_CENTI_MIN = -15'sd4500;
   localparam logic signed [14:0] TEMP_CENTI_MAX = 15'sd13000;
   localparam logic [13:0] HUM_CENTI_MAX = 14'd10000;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [2:0] {
      POS_TEMP_MSB,
      POS_TEMP_LSB,
      POS_TEMP_CRC,
      POS_HUM_MSB,
      POS_HUM_LSB,
      POS_HUM_CRC
   } pos_type;

   typedef struct packed {
      logic [15:0] temp_word;
      logic [15:0] hum_word;
      logic        crc_error;
   } frame_type;

   // msb-first CRC-8 over one byte
   function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // floor(x / 65535) or one less, for x < 2**31
   function automatic logic [15:0] div_full_est(input logic [31:0] x);
      logic [31:0] s;
      s = x + {16'd0, x[31:16]};
      return s[31:16];
   endfunction

   // remainder against the estimate; below 2 * 65535
   function automatic logic [16:0] div_full_rem(input logic [31:0] x, input logic [15:0] q);
      logic [31:0] r;
      r = x - {q, 16'd0} + {16'd0, q};
      return r[16:0];
   endfunction

endpackage

[rtl/core/humidity_temp_frame_decoder_top.sv]
// Top level of the humidity/temperature frame decoder.
//
// Input channel: one received sensor byte per beat on req_rx_byte, taken when
// req_push is high and req_full is low. Bytes come in frame order: temperature
// msb, lsb, CRC, humidity msb, lsb, CRC. Every sixth byte closes a frame.
// Result channel: one beat per frame on the rsp_ ports, valid while rsp_empty
// is low, taken when rsp_pop is high. It carries both scaled readings, both
// raw words and a flag that is set when either CRC-8 (poly 0x31, init 0xFF)
// failed.
// Throughput: one byte per cycle while req_full is low. The result reaches the
// rsp_ ports through the queue, product stage, quotient stage and correction
// stage.
// When rsp_pop stays low the result stage holds, the scaling pipeline fills,
// then the two-entry frame queue; req_full rises only when that queue is full.
// Reset clears the byte position (next byte is a temperature msb), the CRC and
// all valid state; frames in flight are dropped.
`include "assert_macros.svh"

module humidity_temp_frame_decoder_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [14:0] rsp_temperature_centi,
   output logic [13:0]        rsp_humidity_centi,
   output logic [15:0]        rsp_temperature_word,
   output logic [15:0]        rsp_humidity_word,
   output logic               rsp_crc_error
);

   logic                byte_valid;
   logic                frame_push;
   htfd_pkg::frame_type front_frame;
   logic                fifo_full;
   logic                fifo_empty;
   logic                fifo_pop;
   htfd_pkg::frame_type fifo_head;

   assign byte_valid = req_push & ~fifo_full;
   assign req_full   = fifo_full;

   htfd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .rx_byte    (req_rx_byte),
      .frame_push (frame_push),
      .frame      (front_frame)
   );

   htfd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_push),
      .push_data (front_frame),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .empty     (fifo_empty),
      .head      (fifo_head)
   );

   htfd_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .in_empty              (fifo_empty),
      .in_frame              (fifo_head),
      .in_pop                (fifo_pop),
      .out_empty             (rsp_empty),
      .out_pop               (rsp_pop),
      .out_temperature_centi (rsp_temperature_centi),
      .out_humidity_centi    (rsp_humidity_centi),
      .out_temperature_word  (rsp_temperature_word),
      .out_humidity_word     (rsp_humidity_word),
      .out_crc_error         (rsp_crc_error)
   );

   `ASSERT_NEVER(a_no_queue_overflow, clock, reset, frame_push && fifo_full)
   `ASSERT_IMPLY(a_hum_range, clock, reset, !rsp_empty,
                 rsp_humidity_centi <= htfd_pkg::HUM_CENTI_MAX)
   `ASSERT_IMPLY(a_temp_range, clock, reset, !rsp_empty,
                 (rsp_temperature_centi >= htfd_pkg::TEMP_CENTI_MIN) &&
                 (rsp_temperature_centi <= htfd_pkg::TEMP_CENTI_MAX))

endmodule

[rtl/core/htfd_front.sv]
// Front end: collects frame bytes, checks both CRCs and emits one frame record.
module htfd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_valid,
   input  logic [7:0]          rx_byte,
   output logic                frame_push,
   output htfd_pkg::frame_type frame
);

   htfd_pkg::pos_type pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] temp_word_ff, temp_word_in;
   logic [15:0] hum_word_ff, hum_word_in;
   logic        temp_bad_ff, temp_bad_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= htfd_pkg::POS_TEMP_MSB;
         crc_ff      <= htfd_pkg::CRC_INIT;
         temp_bad_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         temp_bad_ff <= temp_bad_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_word_ff <= temp_word_in;
      hum_word_ff  <= hum_word_in;
   end

   always_comb begin
      pos_in       = pos_ff;
      crc_in       = crc_ff;
      temp_word_in = temp_word_ff;
      hum_word_in  = hum_word_ff;
      temp_bad_in  = temp_bad_ff;
      frame_push   = 1'b0;
      frame.temp_word = temp_word_ff;
      frame.hum_word  = hum_word_ff;
      frame.crc_error = temp_bad_ff | (crc_ff != rx_byte);
      if (byte_valid) begin
         unique case (pos_ff)
            htfd_pkg::POS_TEMP_LSB: begin
               crc_in       = htfd_pkg::crc_feed(crc_ff, rx_byte);
               temp_word_in = {temp_word_ff[15:8], rx_byte};
               pos_in       = htfd_pkg::POS_TEMP_CRC;
            end
            htfd_pkg::POS_TEMP_CRC: begin
               temp_bad_in = (crc_ff != rx_byte);
               crc_in      = htfd_pkg::CRC_INIT;
               pos_in      = htfd_pkg::POS_HUM_MSB;
            end
            htfd_pkg::POS_HUM_MSB: begin
               crc_in      = htfd_pkg::crc_feed(htfd_pkg::CRC_INIT, rx_byte);
               hum_word_in = {rx_byte, 8'd0};
               pos_in      = htfd_pkg::POS_HUM_LSB;
            end
            htfd_pkg::POS_HUM_LSB: begin
               crc_in      = htfd_pkg::crc_feed(crc_ff, rx_byte);
               hum_word_in = {hum_word_ff[15:8], rx_byte};
               pos_in      = htfd_pkg::POS_HUM_CRC;
            end
            htfd_pkg::POS_HUM_CRC: begin
               frame_push = 1'b1;
               crc_in     = htfd_pkg::CRC_INIT;
               pos_in     = htfd_pkg::POS_TEMP_MSB;
            end
            default: begin
               // temperature msb; unused codes behave the same
               crc_in       = htfd_pkg::crc_feed(htfd_pkg::CRC_INIT, rx_byte);
               temp_word_in = {rx_byte, 8'd0};
               pos_in       = htfd_pkg::POS_TEMP_LSB;
            end
         endcase
      end
   end

endmodule

[rtl/core/htfd_fifo.sv]
// Short register queue of frame records between front and back end.
module htfd_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  htfd_pkg::frame_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output htfd_pkg::frame_type head
);

   htfd_pkg::frame_type entry_ff [htfd_pkg::FIFO_DEPTH];
   logic [htfd_pkg::FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [htfd_pkg::FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [htfd_pkg::FIFO_CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   localparam logic [htfd_pkg::FIFO_AW-1:0] LAST_PTR =
      htfd_pkg::FIFO_AW'(htfd_pkg::FIFO_DEPTH - 1);

   assign full    = (count_ff == htfd_pkg::FIFO_CW'(htfd_pkg::FIFO_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/htfd_back.sv]
// Back end: scales the raw words in a three-stage stallable pipeline.
module htfd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_empty,
   input  htfd_pkg::frame_type in_frame,
   output logic                in_pop,
   output logic                out_empty,
   input  logic                out_pop,
   output logic signed [14:0]  out_temperature_centi,
   output logic [13:0]         out_humidity_centi,
   output logic [15:0]         out_temperature_word,
   output logic [15:0]         out_humidity_word,
   output logic                out_crc_error
);

   // stage a: products
   logic                        a_valid_ff, a_valid_in;
   logic [htfd_pkg::TPROD_W-1:0] a_tprod_ff;
   logic [htfd_pkg::HPROD_W-1:0] a_hprod_ff;
   htfd_pkg::frame_type         a_frame_ff;
   // stage b: quotient estimates
   logic                        b_valid_ff, b_valid_in;
   logic [htfd_pkg::TPROD_W-1:0] b_tprod_ff;
   logic [htfd_pkg::HPROD_W-1:0] b_hprod_ff;
   logic [14:0]                 b_tq_ff;
   logic [13:0]                 b_hq_ff;
   htfd_pkg::frame_type         b_frame_ff;
   // stage c: result register
   logic                        c_valid_ff, c_valid_in;
   logic signed [14:0]          c_temp_ff;
   logic [13:0]                 c_hum_ff;
   htfd_pkg::frame_type         c_frame_ff;

   logic a_ready, b_ready, c_ready;
   logic a_load, b_load, c_load;
   logic [15:0] tq_est, hq_est;
   logic [16:0] t_rem, h_rem;
   logic [14:0] tq_fix;
   logic [13:0] hq_fix;

   assign c_ready = ~c_valid_ff | out_pop;
   assign b_ready = ~b_valid_ff | c_ready;
   assign a_ready = ~a_valid_ff | b_ready;
   assign in_pop  = ~in_empty & a_ready;
   assign a_load  = in_pop;
   assign b_load  = a_valid_ff & b_ready;
   assign c_load  = b_valid_ff & c_ready;

   always_comb begin
      a_valid_in = a_ready ? ~in_empty : a_valid_ff;
      b_valid_in = b_ready ? a_valid_ff : b_valid_ff;
      c_valid_in = c_ready ? b_valid_ff : c_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
      end
   end

   assign tq_est = htfd_pkg::div_full_est({1'b0, a_tprod_ff});
   assign hq_est = htfd_pkg::div_full_est({2'b0, a_hprod_ff});

   // estimate is floor or floor - 1; remainder decides the fix
   assign t_rem = htfd_pkg::div_full_rem({1'b0, b_tprod_ff}, {1'b0, b_tq_ff});
   assign h_rem = htfd_pkg::div_full_rem({2'b0, b_hprod_ff}, {2'b0, b_hq_ff});
   assign tq_fix = (t_rem >= htfd_pkg::WORD_FULL) ? b_tq_ff + 1'b1 : b_tq_ff;
   assign hq_fix = (h_rem >= htfd_pkg::WORD_FULL) ? b_hq_ff + 1'b1 : b_hq_ff;

   always_ff @(posedge clock) begin
      if (a_load) begin
         a_tprod_ff <= htfd_pkg::TPROD_W'(in_frame.temp_word * htfd_pkg::TEMP_SPAN);
         a_hprod_ff <= htfd_pkg::HPROD_W'(in_frame.hum_word * htfd_pkg::HUM_SPAN);
         a_frame_ff <= in_frame;
      end
      if (b_load) begin
         b_tprod_ff <= a_tprod_ff;
         b_hprod_ff <= a_hprod_ff;
         b_tq_ff    <= tq_est[14:0];
         b_hq_ff    <= hq_est[13:0];
         b_frame_ff <= a_frame_ff;
      end
      if (c_load) begin
         c_temp_ff  <= $signed(tq_fix - htfd_pkg::TEMP_OFFSET);
         c_hum_ff   <= hq_fix;
         c_frame_ff <= b_frame_ff;
      end
   end

   assign out_empty             = ~c_valid_ff;
   assign out_temperature_centi = c_temp_ff;
   assign out_humidity_centi    = c_hum_ff;
   assign out_temperature_word  = c_frame_ff.temp_word;
   assign out_humidity_word     = c_frame_ff.hum_word;
   assign out_crc_error         = c_frame_ff.crc_error;

endmodule

[test/tb_humidity_temp_frame_decoder_top.sv]
// Testbench for the humidity/temperature frame decoder: directed and random frames, scoreboarded.
module tb_humidity_temp_frame_decoder_top;

   typedef struct packed {
      logic [14:0] temp_centi;
      logic [13:0] hum_centi;
      logic [15:0] temp_word;
      logic [15:0] hum_word;
      logic        crc_error;
   } reading_type;

   typedef struct packed {
      logic [15:0] temp_word;
      logic [7:0]  temp_crc;
      logic [15:0] hum_word;
      logic [7:0]  hum_crc;
      logic        fixed;      // want is typed in, not predicted
      reading_type want;
   } frame_plan_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [7:0]         req_rx_byte = 8'h00;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic signed [14:0] rsp_temperature_centi;
   logic [13:0]        rsp_humidity_centi;
   logic [15:0]        rsp_temperature_word;
   logic [15:0]        rsp_humidity_word;
   logic               rsp_crc_error;

   // decoder model state
   htfd_pkg::pos_type next_pos = htfd_pkg::POS_TEMP_MSB;
   logic [7:0]  crc_acc = htfd_pkg::CRC_INIT;
   logic [15:0] temp_acc = 16'h0000;
   logic [15:0] hum_acc = 16'h0000;
   logic        temp_bad = 1'b0;

   reading_type pending_readings[$];
   int          mismatch_count = 0;
   int          bytes_sent = 0;
   int          readings_checked = 0;
   int          crc_error_seen = 0;
   int          send_idle_pct = 0;
   int          pop_stall_pct = 0;
   logic        hold_toggle = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;

   always #6 clock = ~clock;

   humidity_temp_frame_decoder_top uut (
      .clock                 (clock),
      .reset                 (reset),
      .req_push              (req_push),
      .req_full              (req_full),
      .req_rx_byte           (req_rx_byte),
      .rsp_empty             (rsp_empty),
      .rsp_pop               (rsp_pop),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_temperature_word  (rsp_temperature_word),
      .rsp_humidity_word     (rsp_humidity_word),
      .rsp_crc_error         (rsp_crc_error)
   );

   // bit-serial form: feedback is crc msb xor data bit, msb first
   function automatic logic [7:0] crc8(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic       fb;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         fb = c[7] ^ b[i];
         c = {c[6:0], 1'b0} ^ (fb ? htfd_pkg::CRC_POLY : 8'h00);
      end
      return c;
   endfunction

   // advances the frame state by one byte; returns 1 when a reading closes
   function automatic bit decode_byte(input logic [7:0] b, output reading_type r);
      longint tq;
      longint hq;
      r = '0;
      case (next_pos)
         htfd_pkg::POS_TEMP_LSB: begin
            crc_acc = crc8(crc_acc, b);
            temp_acc[7:0] = b;
            next_pos = htfd_pkg::POS_TEMP_CRC;
         end
         htfd_pkg::POS_TEMP_CRC: begin
            temp_bad = (crc_acc != b);
            crc_acc = htfd_pkg::CRC_INIT;
            next_pos = htfd_pkg::POS_HUM_MSB;
         end
         htfd_pkg::POS_HUM_MSB: begin
            crc_acc = crc8(htfd_pkg::CRC_INIT, b);
            hum_acc = {b, 8'h00};
            next_pos = htfd_pkg::POS_HUM_LSB;
         end
         htfd_pkg::POS_HUM_LSB: begin
            crc_acc = crc8(crc_acc, b);
            hum_acc[7:0] = b;
            next_pos = htfd_pkg::POS_HUM_CRC;
         end
         htfd_pkg::POS_HUM_CRC: begin
            tq = (longint'(htfd_pkg::TEMP_SPAN) * longint'(temp_acc)) /
                 longint'(htfd_pkg::WORD_FULL);
            hq = (longint'(htfd_pkg::HUM_SPAN) * longint'(hum_acc)) /
                 longint'(htfd_pkg::WORD_FULL);
            r.temp_centi = 15'(tq - longint'(htfd_pkg::TEMP_OFFSET));
            r.hum_centi = 14'(hq);
            r.temp_word = temp_acc;
            r.hum_word = hum_acc;
            r.crc_error = temp_bad | (crc_acc != b);
            crc_acc = htfd_pkg::CRC_INIT;
            next_pos = htfd_pkg::POS_TEMP_MSB;
            return 1'b1;
         end
         default: begin
            crc_acc = crc8(htfd_pkg::CRC_INIT, b);
            temp_acc = {b, 8'h00};
            next_pos = htfd_pkg::POS_TEMP_LSB;
         end
      endcase
      return 1'b0;
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(255));
         3: return 16'hFFFF - 16'($urandom_range(255));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic fixed, input reading_type want);
      reading_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      bytes_sent++;
      if (decode_byte(b, r)) pending_readings.push_back(fixed ? want : r);
   endtask

   task automatic send_frame(input frame_plan_type f);
      send_byte(f.temp_word[15:8], f.fixed, f.want);
      send_byte(f.temp_word[7:0], f.fixed, f.want);
      send_byte(f.temp_crc, f.fixed, f.want);
      send_byte(f.hum_word[15:8], f.fixed, f.want);
      send_byte(f.hum_word[7:0], f.fixed, f.want);
      send_byte(f.hum_crc, f.fixed, f.want);
   endtask

   task automatic send_random_frame();
      frame_plan_type f;
      int             kind;
      f = '0;
      f.temp_word = pick_word();
      f.hum_word = pick_word();
      f.temp_crc = crc8(crc8(htfd_pkg::CRC_INIT, f.temp_word[15:8]), f.temp_word[7:0]);
      f.hum_crc = crc8(crc8(htfd_pkg::CRC_INIT, f.hum_word[15:8]), f.hum_word[7:0]);
      kind = $urandom_range(99);
      if (kind >= 95) begin
         f.temp_crc = 8'($urandom);
         f.hum_crc = 8'($urandom);
      end else if (kind >= 85) begin
         f.hum_crc ^= 8'($urandom_range(1, 255));
      end else if (kind >= 70) begin
         f.temp_crc ^= 8'($urandom_range(1, 255));
      end
      send_frame(f);
   endtask

   // sender stops until every reading is back
   task automatic drain();
      req_push <= 1'b0;
      do @(posedge clock); while (pending_readings.size() != 0);
   endtask

   task automatic run_phase(input int frames, input int send_pct, input int pop_pct,
                            input bit long_hold);
      send_idle_pct = send_pct;
      pop_stall_pct <= pop_pct;
      if (long_hold) hold_toggle <= ~hold_toggle;
      repeat (frames) send_random_frame();
      drain();
   endtask

   // receiver: random stalls, plus a long hold started by a toggle from the sender
   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen <= hold_toggle;
         hold_left <= 300;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
      rsp_pop <= !reset && hold_left == 0 && hold_toggle == hold_seen &&
                 $urandom_range(99) >= pop_stall_pct;
   end

   always @(posedge clock) begin
      reading_type w;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_readings.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual words %h %h", $time,
                     rsp_temperature_word, rsp_humidity_word);
            mismatch_count++;
         end else begin
            w = pending_readings.pop_front();
            check_field("temperature_centi", $signed(w.temp_centi), rsp_temperature_centi);
            check_field("humidity_centi", w.hum_centi, rsp_humidity_centi);
            check_field("temperature_word", w.temp_word, rsp_temperature_word);
            check_field("humidity_word", w.hum_word, rsp_humidity_word);
            check_field("crc_error", w.crc_error, rsp_crc_error);
            readings_checked++;
            if (rsp_crc_error) crc_error_seen++;
         end
      end
   end

   initial begin
      frame_plan_type directed_frames [4];
      // checksums: 0x81 covers 0x0000, 0xAC covers 0xFFFF, 0x92 covers 0xBEEF
      directed_frames[0] = '{16'h0000, 8'h81, 16'h0000, 8'h81, 1'b1,
                             '{htfd_pkg::TEMP_CENTI_MIN, 14'd0, 16'h0000, 16'h0000, 1'b0}};
      directed_frames[1] = '{16'hFFFF, 8'hAC, 16'hFFFF, 8'hAC, 1'b1,
                             '{htfd_pkg::TEMP_CENTI_MAX, htfd_pkg::HUM_CENTI_MAX,
                               16'hFFFF, 16'hFFFF, 1'b0}};
      directed_frames[2] = '{16'hFFFF, 8'h00, 16'h0000, 8'h81, 1'b1,
                             '{htfd_pkg::TEMP_CENTI_MAX, 14'd0, 16'hFFFF, 16'h0000, 1'b1}};
      directed_frames[3] = '{16'hBEEF, 8'h92, 16'h1234, 8'h00, 1'b0, '0};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      if (rsp_empty !== 1'b1) begin
         $display("%0t: rsp_empty after reset, expected 1, actual %b", $time, rsp_empty);
         mismatch_count++;
      end

      foreach (directed_frames[i]) send_frame(directed_frames[i]);
      drain();

      run_phase(45, 0, 0, 1'b0);
      run_phase(45, 51, 0, 1'b0);
      run_phase(45, 0, 51, 1'b0);
      run_phase(45, 22, 22, 1'b0);
      // receiver holds off while bytes keep coming: queue fills, req_full must stall us
      run_phase(25, 0, 0, 1'b1);

      repeat (16) @(posedge clock);
      $display("%0d bytes pushed, %0d readings checked, %0d of them with a bad checksum",
               bytes_sent, readings_checked, crc_error_seen);
      $display("covered word extremes, checksum faults, free flow, gaps, stalls and a full queue");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #2400000;
      $display("timeout with %0d readings outstanding", pending_readings.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule
